FILE: rtl/core/dq_pkg.sv
// Shared types and constants for the double-ended queue.
// Used by the controller, the datapath and the top level; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dq_pkg;

  // Field widths fixed by the item format
  localparam int unsigned OP_W     = 3;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned OCC_W    = 5;
  localparam int unsigned HOME_W   = 5;

  // Defaults
  localparam int unsigned DEPTH_DEFAULT = 16;
  localparam int unsigned HOME_RESET    = 16;

  // Operation codes; codes 5 to 7 are no-ops
  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_CLEAR      = 3'd4
  } opcode_e;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    STAT_OK      = 2'd0,
    STAT_NO_ROOM = 2'd1,
    STAT_EMPTY   = 2'd2
  } status_e;

  // Controller states
  typedef enum logic [1:0] {
    CTRL_IDLE,
    CTRL_READ,
    CTRL_RESP
  } ctrl_state_e;

  // Input item
  typedef struct packed {
    logic [OP_W-1:0]          opcode;
    logic signed [WORD_W-1:0] push_value;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic signed [WORD_W-1:0] pop_value;
    logic [STATUS_W-1:0]      status;
    logic [OCC_W-1:0]         occupancy;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic exec;     // apply the accepted item
    logic capture;  // latch the RAM read data as the popped word
  } dq_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic pop_read; // item at the input is a pop that succeeds
  } dq_stat_t;

endpackage

`default_nettype wire

FILE: rtl/core/dq_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module dq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: rtl/core/dq_ctrl.sv
// Controller for the double-ended queue: accepts one item, waits on the
// RAM read for pops, then presents the result. Depends on dq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dq_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  input  wire dq_pkg::dq_stat_t stat_i,
  output dq_pkg::dq_cmd_t       cmd_o
);

  import dq_pkg::*;

  ctrl_state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CTRL_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d       = state_q;
    in_ready_o    = 1'b0;
    out_valid_o   = 1'b0;
    cmd_o.exec    = 1'b0;
    cmd_o.capture = 1'b0;
    unique case (state_q)
      CTRL_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.exec = 1'b1;
          state_d    = stat_i.pop_read ? CTRL_READ : CTRL_RESP;
        end
      end
      CTRL_READ: begin
        // read data is out of the RAM now
        cmd_o.capture = 1'b1;
        state_d       = CTRL_RESP;
      end
      CTRL_RESP: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = CTRL_IDLE;
        end
      end
      default: begin
        state_d = CTRL_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/core/dq_datapath.sv
// Datapath for the double-ended queue: end indices, home register, word
// store and result register. Depends on dq_pkg and dq_ram.
`timescale 1ns / 1ps
`default_nettype none

module dq_datapath #(
  parameter int unsigned DEPTH = dq_pkg::DEPTH_DEFAULT
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire dq_pkg::in_item_t          in_data_i,
  input  wire logic                      cfg_we_i,
  input  wire logic [dq_pkg::HOME_W-1:0] cfg_data_i,
  input  wire dq_pkg::dq_cmd_t           cmd_i,
  output dq_pkg::dq_stat_t               stat_o,
  output dq_pkg::out_item_t              out_data_o
);

  import dq_pkg::*;

  localparam int unsigned IDX_W      = $clog2(DEPTH + 1);
  localparam int unsigned ADDR_W     = $clog2(DEPTH);
  localparam int unsigned RESET_HOME = (HOME_RESET > DEPTH) ? DEPTH : HOME_RESET;
  localparam logic [IDX_W-1:0] DEPTH_IDX = IDX_W'(DEPTH);

  logic [HOME_W-1:0]   home_q;
  logic [IDX_W-1:0]    front_q, front_d;
  logic [IDX_W-1:0]    back_q, back_d;
  logic [IDX_W-1:0]    home_idx;
  logic [IDX_W-1:0]    occ_diff;
  logic                ram_we, ram_re;
  logic [ADDR_W-1:0]   ram_waddr, ram_raddr;
  logic [WORD_W-1:0]   ram_rdata;
  status_e             status_d;
  logic [WORD_W-1:0]   pop_value_q;
  logic [STATUS_W-1:0] status_q;
  logic [OCC_W-1:0]    occ_q;

  // Home register, clipped to the array size where used
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      home_q <= HOME_W'(HOME_RESET);
    end else if (cfg_we_i) begin
      home_q <= cfg_data_i;
    end
  end

  assign home_idx = (32'(home_q) > 32'(DEPTH)) ? DEPTH_IDX : IDX_W'(home_q);

  // Operation decode: next indices, RAM access and status
  always_comb begin
    front_d   = front_q;
    back_d    = back_q;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = ADDR_W'(front_q);
    ram_raddr = ADDR_W'(front_q);
    status_d  = STAT_OK;
    unique case (opcode_e'(in_data_i.opcode))
      OP_PUSH_FRONT: begin
        if (front_q != '0 && front_q <= DEPTH_IDX) begin
          front_d   = front_q - IDX_W'(1);
          ram_we    = 1'b1;
          ram_waddr = ADDR_W'(front_d);
        end else begin
          status_d = STAT_NO_ROOM;
        end
      end
      OP_PUSH_BACK: begin
        if (back_q < DEPTH_IDX) begin
          back_d    = back_q + IDX_W'(1);
          ram_we    = 1'b1;
          ram_waddr = ADDR_W'(back_q);
        end else begin
          status_d = STAT_NO_ROOM;
        end
      end
      OP_POP_FRONT: begin
        if (front_q < back_q && front_q < DEPTH_IDX) begin
          front_d   = front_q + IDX_W'(1);
          ram_re    = 1'b1;
          ram_raddr = ADDR_W'(front_q);
        end else begin
          status_d = STAT_EMPTY;
        end
      end
      OP_POP_BACK: begin
        if (back_q > front_q && back_q <= DEPTH_IDX) begin
          back_d    = back_q - IDX_W'(1);
          ram_re    = 1'b1;
          ram_raddr = ADDR_W'(back_d);
        end else begin
          status_d = STAT_EMPTY;
        end
      end
      OP_CLEAR: begin
        front_d = home_idx;
        back_d  = home_idx;
      end
      default: begin
        // unused codes change nothing
      end
    endcase
  end

  assign stat_o.pop_read = ram_re;
  assign occ_diff        = back_d - front_d;

  // End indices
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= IDX_W'(RESET_HOME);
      back_q  <= IDX_W'(RESET_HOME);
    end else if (cmd_i.exec) begin
      front_q <= front_d;
      back_q  <= back_d;
    end
  end

  // Word store
  dq_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.exec & ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (in_data_i.push_value),
    .re_i    (cmd_i.exec & ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      pop_value_q <= '0;
      status_q    <= status_d;
      occ_q       <= OCC_W'(occ_diff);
    end else if (cmd_i.capture) begin
      pop_value_q <= ram_rdata;
    end
  end

  assign out_data_o.pop_value = pop_value_q;
  assign out_data_o.status    = status_q;
  assign out_data_o.occupancy = occ_q;

endmodule

`default_nettype wire

FILE: rtl/core/double_ended_queue.sv
// Double-ended queue of signed 32-bit words in a fixed, non-wrapping array.
// Top level joining dq_ctrl and dq_datapath; depends on dq_pkg.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o/in_data_i) carries one operation:
//   push front, push back, pop front, pop back or clear. Every transfer gives
//   exactly one result on the output channel (out_valid_o/out_ready_i/
//   out_data_o): popped word, status (ok, no room, empty) and occupancy.
//   cfg_we_i/cfg_data_i write the home index used by clear; it takes effect
//   on the next clear only.
//   One item at a time: a push, clear, no-op or failed pop shows its result
//   in the cycle after the transfer; a successful pop first passes the read
//   state, as the word store has a registered read port. The result then holds until
//   the receiver takes it; in_ready_o stays low meanwhile, so a stalled
//   receiver stalls the sender. A new item is taken only after the result is
//   taken and the controller is back in its idle state.
//   Reset puts both ends at home index 16 (clipped to DEPTH) and the home
//   register at 16. Store contents are not cleared; only words between the
//   ends are ever read.
`timescale 1ns / 1ps
`default_nettype none

module double_ended_queue #(
  parameter int unsigned DEPTH = dq_pkg::DEPTH_DEFAULT
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire dq_pkg::in_item_t          in_data_i,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output dq_pkg::out_item_t              out_data_o,
  input  wire logic                      cfg_we_i,
  input  wire logic [dq_pkg::HOME_W-1:0] cfg_data_i
);

  import dq_pkg::*;

  dq_cmd_t  cmd;
  dq_stat_t stat;

  // Sequencing
  dq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // Indices, store and result
  dq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .out_data_o (out_data_o)
  );

  // Never take a new item while a result is pending
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input ready while result pending");

  // A transfer blocks further input on the next cycle
  a_accept_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("second item taken before result delivered");

  // Failed pop and failed push results carry zero data
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.status == STAT_EMPTY ||
                     out_data_o.status == STAT_NO_ROOM)) |-> (out_data_o.pop_value == '0))
    else $error("nonzero word on failed operation");

  // Occupancy never exceeds the array size (checked only for DEPTH up to 31)
  a_occ_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (DEPTH > 31 || 32'(out_data_o.occupancy) <= DEPTH))
    else $error("occupancy out of range");

endmodule

`default_nettype wire
